// ===== hw/rtl/modular_arithmetic_unit_defines.svh =====
// Assertion macros shared by the modular arithmetic unit RTL.
`ifndef MODULAR_ARITHMETIC_UNIT_DEFINES_SVH
`define MODULAR_ARITHMETIC_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define MAU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MAU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mau_pkg.sv =====
// Package: widths, codes, sequencer states and shared-unit structs.
`timescale 1ns / 1ps
package mau_pkg;

    localparam int WIDTH     = 32;
    localparam int EXP_WIDTH = 64;
    localparam int OPND_W    = 32;
    localparam int EXPF_W    = 64;
    localparam int KIND_W    = 3;
    localparam int CNT_W     = $clog2(WIDTH);

    localparam logic [OPND_W-1:0] MOD_RESET = 32'd1000000007;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD = 3'd0,
        KIND_SUB = 3'd1,
        KIND_MUL = 3'd2,
        KIND_DIV = 3'd3,
        KIND_POW = 3'd4
    } mau_kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED_A,
        S_RED_B,
        S_OP,
        S_MUL,
        S_PW_TEST,
        S_PW_ACC,
        S_PW_SQR,
        S_DIV_MUL,
        S_OUT
    } mau_state_t;

    typedef struct packed {
        logic             start;
        logic [WIDTH-1:0] x;
        logic [WIDTH-1:0] y;
    } mau_mul_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [WIDTH-1:0] product;
    } mau_mul_rsp_t;

endpackage

// ===== hw/rtl/mau_in_if.sv =====
// Input channel: valid/ready handshake with the operation item.
`timescale 1ns / 1ps
interface mau_in_if import mau_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [OPND_W-1:0] operand_a;
    logic [OPND_W-1:0] operand_b;
    logic [EXPF_W-1:0] exponent;

    modport source (output valid, output kind, output operand_a, output operand_b,
                    output exponent, input ready);
    modport sink   (input valid, input kind, input operand_a, input operand_b,
                    input exponent, output ready);
endinterface

// ===== hw/rtl/mau_out_if.sv =====
// Output channel: valid/ready handshake with the result item.
`timescale 1ns / 1ps
interface mau_out_if import mau_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OPND_W-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

// ===== hw/rtl/mau_mulmod.sv =====
// Shared modular multiplier: interleaved shift-add, one multiplier bit per cycle.
`timescale 1ns / 1ps
module mau_mulmod
    import mau_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [WIDTH-1:0] modulus,
    input  mau_mul_req_t     req,
    output mau_mul_rsp_t     rsp
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [WIDTH-1:0] x_reg;
    logic [WIDTH-1:0] y_reg;
    logic [WIDTH-1:0] r_reg;

    logic [WIDTH+1:0] t;
    logic [WIDTH+1:0] m1;
    logic [WIDTH+1:0] m2;
    logic [WIDTH-1:0] r_next;

    // r < m and x < m, so 2r + x < 3m: at most two subtractions of m
    always_comb
    begin
        t  = {1'b0, r_reg, 1'b0} + {2'b00, (y_reg[WIDTH-1] ? x_reg : '0)};
        m1 = {2'b00, modulus};
        m2 = {1'b0, modulus, 1'b0};
        if (t >= m2)
        begin
            r_next = WIDTH'(t - m2);
        end
        else if (t >= m1)
        begin
            r_next = WIDTH'(t - m1);
        end
        else
        begin
            r_next = t[WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(WIDTH - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            r_reg <= r_next;
            y_reg <= {y_reg[WIDTH-2:0], 1'b0};
        end
        else if (req.start)
        begin
            r_reg <= '0;
            x_reg <= req.x;
            y_reg <= req.y;
        end
    end

    assign rsp.busy    = busy_reg;
    assign rsp.done    = done_reg;
    assign rsp.product = r_reg;

endmodule

// ===== hw/rtl/modular_arithmetic_unit.sv =====
// Modular arithmetic unit: one shared modular multiplier under a sequencer.
// Add and subtract reduce both operands with the multiplier, then combine them; multiply adds
// one modular multiply after that; a modulus below two goes straight to a zero result. Power
// is square-and-multiply: one multiply per set exponent bit, one square per bit below the top set
// one; divide is power over exponent m-2 then a multiply, or zero for a zero divisor. One item at a time:
// next accepted the cycle after the result loads. Reset: idle, no valid, modulus 1000000007.
`timescale 1ns / 1ps
`include "modular_arithmetic_unit_defines.svh"
module modular_arithmetic_unit
    import mau_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [OPND_W-1:0] cfg_wr_data,
    mau_in_if.sink            in_ch,
    mau_out_if.source         out_ch
);

    mau_state_t           state_reg;
    mau_state_t           state_next;
    logic [WIDTH-1:0]     modulus_reg;
    logic [KIND_W-1:0]    kind_reg;
    logic [WIDTH-1:0]     a_reg;
    logic [WIDTH-1:0]     b_reg;
    logic [WIDTH-1:0]     acc_reg;
    logic [WIDTH-1:0]     p_reg;
    logic [EXP_WIDTH-1:0] e_reg;
    logic [WIDTH-1:0]     res_reg;
    logic                 out_valid_reg;
    logic [WIDTH-1:0]     out_data_reg;

    mau_mul_req_t         mul_req;
    mau_mul_rsp_t         mul_rsp;

    logic                 accept;
    logic                 mod_small;
    logic                 mul_state;
    logic                 out_load;
    logic [WIDTH:0]       add_sum;
    logic [WIDTH-1:0]     add_res;
    logic [WIDTH-1:0]     sub_res;
    logic                 e_last;

    mau_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .modulus (modulus_reg),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    assign accept    = in_ch.valid && in_ch.ready;
    assign mod_small = (modulus_reg <= WIDTH'(1));
    assign e_last    = (e_reg[EXP_WIDTH-1:1] == '0);

    always_comb
    begin
        add_sum = {1'b0, a_reg} + {1'b0, b_reg};
        if (add_sum >= {1'b0, modulus_reg})
        begin
            add_res = WIDTH'(add_sum - {1'b0, modulus_reg});
        end
        else
        begin
            add_res = add_sum[WIDTH-1:0];
        end
        // a + m - b fits in WIDTH bits when a < b, so wraparound is exact
        if (a_reg >= b_reg)
        begin
            sub_res = a_reg - b_reg;
        end
        else
        begin
            sub_res = a_reg + modulus_reg - b_reg;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = mod_small ? S_OUT : S_RED_A;
                end
            end
            S_RED_A:
            begin
                if (mul_rsp.done)
                begin
                    state_next = S_RED_B;
                end
            end
            S_RED_B:
            begin
                if (mul_rsp.done)
                begin
                    state_next = S_OP;
                end
            end
            S_OP:
            begin
                case (kind_reg)
                    KIND_MUL: state_next = S_MUL;
                    KIND_DIV: state_next = (b_reg == '0) ? S_OUT : S_PW_TEST;
                    KIND_POW: state_next = S_PW_TEST;
                    default:  state_next = S_OUT;
                endcase
            end
            S_MUL, S_DIV_MUL:
            begin
                if (mul_rsp.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_PW_TEST:
            begin
                if (e_reg == '0)
                begin
                    state_next = (kind_reg == KIND_DIV) ? S_DIV_MUL : S_OUT;
                end
                else if (e_reg[0])
                begin
                    state_next = S_PW_ACC;
                end
                else
                begin
                    state_next = S_PW_SQR;
                end
            end
            S_PW_ACC:
            begin
                if (mul_rsp.done)
                begin
                    state_next = e_last ? S_PW_TEST : S_PW_SQR;
                end
            end
            S_PW_SQR:
            begin
                if (mul_rsp.done)
                begin
                    state_next = S_PW_TEST;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ch.ready = (state_reg == S_IDLE);
        out_load    = (state_reg == S_OUT) && (!out_valid_reg || out_ch.ready);
        mul_state   = 1'b1;
        mul_req.x   = WIDTH'(1);
        mul_req.y   = a_reg;
        case (state_reg)
            S_RED_A:
            begin
                mul_req.y = a_reg;
            end
            S_RED_B:
            begin
                mul_req.y = b_reg;
            end
            S_MUL:
            begin
                mul_req.x = a_reg;
                mul_req.y = b_reg;
            end
            S_PW_ACC:
            begin
                mul_req.x = acc_reg;
                mul_req.y = p_reg;
            end
            S_PW_SQR:
            begin
                mul_req.x = p_reg;
                mul_req.y = p_reg;
            end
            S_DIV_MUL:
            begin
                mul_req.x = a_reg;
                mul_req.y = acc_reg;
            end
            default:
            begin
                mul_state = 1'b0;
            end
        endcase
        mul_req.start = mul_state && !mul_rsp.busy && !mul_rsp.done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            modulus_reg   <= MOD_RESET[WIDTH-1:0];
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                modulus_reg <= cfg_wr_data[WIDTH-1:0];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= res_reg;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_reg <= in_ch.kind;
                    a_reg    <= in_ch.operand_a[WIDTH-1:0];
                    b_reg    <= in_ch.operand_b[WIDTH-1:0];
                    e_reg    <= in_ch.exponent[EXP_WIDTH-1:0];
                    res_reg  <= '0;
                end
            end
            S_RED_A:
            begin
                if (mul_rsp.done)
                begin
                    a_reg <= mul_rsp.product;
                end
            end
            S_RED_B:
            begin
                if (mul_rsp.done)
                begin
                    b_reg <= mul_rsp.product;
                end
            end
            S_OP:
            begin
                acc_reg <= WIDTH'(1);
                case (kind_reg)
                    KIND_ADD: res_reg <= add_res;
                    KIND_SUB: res_reg <= sub_res;
                    KIND_DIV:
                    begin
                        // Fermat inverse: b^(m-2)
                        p_reg   <= b_reg;
                        e_reg   <= EXP_WIDTH'(modulus_reg - WIDTH'(2));
                        res_reg <= '0;
                    end
                    KIND_POW: p_reg <= a_reg;
                    default:  res_reg <= '0;
                endcase
            end
            S_PW_TEST:
            begin
                res_reg <= acc_reg;
            end
            S_PW_ACC:
            begin
                if (mul_rsp.done)
                begin
                    acc_reg <= mul_rsp.product;
                    if (e_last)
                    begin
                        e_reg <= '0;
                    end
                end
            end
            S_PW_SQR:
            begin
                if (mul_rsp.done)
                begin
                    p_reg <= mul_rsp.product;
                    e_reg <= e_reg >> 1;
                end
            end
            S_MUL, S_DIV_MUL:
            begin
                if (mul_rsp.done)
                begin
                    res_reg <= mul_rsp.product;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.result = OPND_W'(out_data_reg);

    `MAU_ASSERT_NXT(a_enter_busy, clk, rst_n, accept, state_reg != S_IDLE, "item accepted but sequencer stayed idle")
    `MAU_ASSERT_IMP(a_out_range, clk, rst_n, out_valid_reg && !mod_small, out_data_reg < modulus_reg, "result not below modulus")
    `MAU_ASSERT_IMP(a_out_small, clk, rst_n, out_valid_reg && mod_small, out_data_reg == '0, "nonzero result for modulus below two")
    `MAU_ASSERT_IMP(a_mul_range, clk, rst_n, mul_rsp.done, mul_rsp.product < modulus_reg, "multiplier product not reduced")
    `MAU_ASSERT_IMP(a_mul_idle, clk, rst_n, state_reg == S_IDLE, !mul_rsp.busy, "multiplier busy while sequencer idle")

endmodule

// ===== bench/tb_modular_arithmetic_unit.sv =====
// Self-checking bench for the modular arithmetic unit: directed and random items over several moduli.
`timescale 1ns / 1ps
module tb_modular_arithmetic_unit;
    import mau_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 4;
    localparam int STALL_LIMIT   = 50000;
    localparam int HOLD_CYCLES   = 600;
    localparam int BLOCK_ITEMS   = 100;
    localparam int NUM_BLOCKS    = 9;
    localparam int DRAIN_CYCLES  = 40;

    // Expected results of accepted items, predicted under the current modulus.
    class mod_result_board;
        bit [OPND_W-1:0] expected_q[$];
        bit [OPND_W-1:0] modulus;
        int              errors;

        function new();
            modulus = MOD_RESET;
            errors  = 0;
        endfunction

        function void set_modulus(bit [OPND_W-1:0] value);
            modulus = value;
        endfunction

        function bit [63:0] mul_mod(bit [63:0] x, bit [63:0] y, bit [63:0] m);
            return (x * y) % m;
        endfunction

        function bit [63:0] pow_mod(bit [63:0] base, bit [63:0] e, bit [63:0] m);
            bit [63:0] acc;
            bit [63:0] p;
            acc = 64'd1 % m;
            p   = base % m;
            while (e != 0) begin
                if (e[0])
                    acc = mul_mod(acc, p, m);
                p = mul_mod(p, p, m);
                e = e >> 1;
            end
            return acc;
        endfunction

        function bit [OPND_W-1:0] mod_result(logic [KIND_W-1:0] kind, bit [OPND_W-1:0] opa,
                                             bit [OPND_W-1:0] opb, bit [EXPF_W-1:0] e);
            bit [63:0] m;
            bit [63:0] a;
            bit [63:0] b;
            bit [63:0] r;
            m = modulus;
            if (m == 0)
                return '0;
            a = opa % m;
            b = opb % m;
            case (kind)
                KIND_ADD:
                begin
                    r = a + b;
                    if (r >= m)
                        r = r - m;
                end
                KIND_SUB: r = (a >= b) ? a - b : a + m - b;
                KIND_MUL: r = mul_mod(a, b, m);
                KIND_DIV:
                begin
                    if (b == 0)
                        r = 0;
                    else
                        r = mul_mod(a, pow_mod(b, m - 2, m), m);
                end
                KIND_POW: r = pow_mod(a, e, m);
                default:  r = 0;
            endcase
            return r[OPND_W-1:0];
        endfunction

        function void note_operation(logic [KIND_W-1:0] kind, bit [OPND_W-1:0] opa,
                                     bit [OPND_W-1:0] opb, bit [EXPF_W-1:0] e);
            expected_q.push_back(mod_result(kind, opa, opb, e));
        endfunction

        function void check_result(bit [OPND_W-1:0] actual);
            bit [OPND_W-1:0] want;
            if (expected_q.size() == 0) begin
                $error("result: unexpected item, actual %0d", actual);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (actual !== want) begin
                $error("result mismatch: expected %0d, actual %0d", want, actual);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [OPND_W-1:0] cfg_wr_data;

    mau_in_if  in_ch ();
    mau_out_if out_ch ();

    modular_arithmetic_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    mod_result_board board = new();

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_req;
    int quiet_cycles;

    always #HALF_PERIOD clk = ~clk;

    // Result monitor and stall watchdog.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_result(out_ch.result);
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_modular_arithmetic_unit: FAIL");
            $finish;
        end
    end

    // Result receiver: random back-pressure plus one long hold-off on request.
    initial
    begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic offer_op(input logic [KIND_W-1:0] kind, input bit [OPND_W-1:0] opa,
                            input bit [OPND_W-1:0] opb, input bit [EXPF_W-1:0] e);
        if ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= kind;
        in_ch.operand_a <= opa;
        in_ch.operand_b <= opb;
        in_ch.exponent  <= e;
        do @(posedge clk); while (!in_ch.ready);
        board.note_operation(kind, opa, opb, e);
    endtask

    // Drop valid after the last item of a burst, wait for all results, then write.
    task automatic write_modulus(input bit [OPND_W-1:0] value);
        in_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        board.set_modulus(value);
    endtask

    function automatic bit [OPND_W-1:0] pick_operand(bit [OPND_W-1:0] m);
        case ($urandom_range(9))
            0:       return '0;
            1:       return m - 1;
            2:       return m;
            3:       return '1;
            4, 5, 6: return (m == 0) ? $urandom : $urandom % m;
            default: return $urandom;
        endcase
    endfunction

    function automatic bit [EXPF_W-1:0] pick_exponent();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return EXPF_W'($urandom_range(255));
        else if (r < 90)
            return {32'h0, $urandom};
        else
            return {$urandom, $urandom};
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 22)
            return KIND_ADD;
        else if (r < 44)
            return KIND_SUB;
        else if (r < 66)
            return KIND_MUL;
        else if (r < 80)
            return KIND_DIV;
        else if (r < 94)
            return KIND_POW;
        else
            return KIND_POW + KIND_W'($urandom_range(1, 3));
    endfunction

    task automatic run_random_block(input int count);
        logic [KIND_W-1:0] kind;
        bit [OPND_W-1:0]   m;
        m = board.modulus;
        for (int i = 0; i < count; i++) begin
            kind = pick_kind();
            offer_op(kind, pick_operand(m), pick_operand(m), pick_exponent());
        end
    endtask

    initial
    begin
        bit [OPND_W-1:0] mod_list[NUM_BLOCKS];
        bit [OPND_W-1:0] m;

        rst_n           <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_wr_data     <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.kind      <= KIND_ADD;
        in_ch.operand_a <= '0;
        in_ch.operand_b <= '0;
        in_ch.exponent  <= '0;
        hold_req      = 1'b0;
        quiet_cycles  = 0;
        send_idle_pct = 11;
        recv_idle_pct = 82;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items under the reset modulus.
        m = MOD_RESET;
        offer_op(KIND_ADD, '1, '1, '0);
        offer_op(KIND_ADD, m - 1, 32'd1, '0);
        offer_op(KIND_SUB, 32'd5, 32'd9, '0);
        offer_op(KIND_SUB, '1, '0, '0);
        offer_op(KIND_MUL, '1, '1, '0);
        offer_op(KIND_MUL, m - 1, m - 1, '0);
        offer_op(KIND_DIV, 32'd12345, '0, '0);      // divide by zero
        offer_op(KIND_DIV, 32'd7, m, '0);           // divisor reduces to zero
        offer_op(KIND_DIV, '1, 32'd3, '0);
        offer_op(KIND_POW, 32'd2, 32'd0, '0);       // zero exponent
        offer_op(KIND_POW, 32'd3, '0, '1);          // all exponent bits set
        offer_op(KIND_POW, '0, '0, 64'd1);
        offer_op(KIND_POW, m - 1, '1, 64'd1);
        offer_op(KIND_POW + KIND_W'(1), '1, '1, '1); // unused kinds
        offer_op(KIND_POW + KIND_W'(3), 32'd9, 32'd4, '0);

        // Modulus two: inverse exponent is zero.
        write_modulus(32'd2);
        offer_op(KIND_DIV, 32'd3, 32'd1, '0);
        offer_op(KIND_DIV, 32'hFFFF_FFFE, 32'd5, '0);
        offer_op(KIND_POW, 32'd3, '0, {$urandom, $urandom});
        offer_op(KIND_SUB, '0, 32'd1, '0);

        // Modulus one: everything reduces to zero.
        write_modulus(32'd1);
        offer_op(KIND_ADD, '1, 32'd7, '0);
        offer_op(KIND_POW, 32'd5, '0, '0);
        offer_op(KIND_DIV, 32'd5, 32'd3, '0);

        // Zero modulus.
        write_modulus(32'd0);
        offer_op(KIND_MUL, '1, '1, '0);
        offer_op(KIND_POW, 32'd4, '0, '0);
        offer_op(KIND_ADD, 32'd1, 32'd2, '0);

        mod_list[0] = 32'd4294967291;
        mod_list[1] = 32'd2;
        mod_list[2] = 32'hFFFF_FFFF;
        mod_list[3] = 32'd65521;
        mod_list[4] = 32'd3;
        mod_list[5] = 32'd2147483647;
        mod_list[6] = $urandom;
        if (mod_list[6] < 2)
            mod_list[6] = 32'd2;
        mod_list[7] = 32'd998244353;
        mod_list[8] = MOD_RESET;

        for (int blk = 0; blk < NUM_BLOCKS; blk++) begin
            write_modulus(mod_list[blk]);
            case (blk / 3)
                0:
                begin
                    send_idle_pct = 11;
                    recv_idle_pct = 82;
                end
                1:
                begin
                    send_idle_pct = 82;
                    recv_idle_pct = 11;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            // Long receiver hold-off while the sender keeps offering.
            if (blk == 6)
                hold_req = 1'b1;
            run_random_block(BLOCK_ITEMS);
        end

        in_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("tb_modular_arithmetic_unit: PASS");
        else
            $display("tb_modular_arithmetic_unit: FAIL");
        $finish;
    end

endmodule
